// ===== sv/pvp_pkg.sv =====
// Package for the perspective vertex projection unit.
// Widths, reset values, register indexes and shared pipeline types.
// No dependencies.
package pvp_pkg;

  localparam int DataWidth = 32;
  localparam int FracBitsDefault = 16;
  localparam int NumRegs = 7;
  localparam int CfgIdxWidth = 3;

  // Divide quotient magnitude bits; enough to detect overflow of the 32 bit range.
  localparam int QuotWidth = 33;

  // Register indexes.
  localparam logic [CfgIdxWidth-1:0] RegXScale = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegYScale = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegDepthScale = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegDepthOffset = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegCameraX = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegCameraY = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegCameraZ = 3'd6;

  localparam logic signed [DataWidth-1:0] XScaleReset = 32'sd65536;
  localparam logic signed [DataWidth-1:0] YScaleReset = 32'sd65536;
  localparam logic signed [DataWidth-1:0] DepthScaleReset = -32'sd65536;

  localparam logic signed [DataWidth-1:0] S32Max = 32'sh7fffffff;
  localparam logic signed [DataWidth-1:0] S32Min = 32'sh80000000;

  // State carried down the divider chain for one lane.
  typedef struct packed {
    logic                      neg;  // quotient sign
    logic                      ovf;  // quotient too wide for the chain, saturate
    logic [QuotWidth-1:0]      quot; // quotient bits developed so far
    logic [DataWidth+47:0]     rem;  // partial remainder / shifted numerator
  } pvp_lane_t;

  // Per-vertex control that travels alongside the lanes.
  typedef struct packed {
    logic                      valid;
    logic                      w_zero;
    logic                      sat;
    logic [DataWidth:0]        w_mag;  // |w|, 33 bits
  } pvp_ctrl_t;

  function automatic logic signed [DataWidth-1:0] clamp64(
      input logic signed [65:0] v, output logic sat);
    begin
      sat = 1'b0;
      if (v > 66'sh07fffffff) begin
        sat = 1'b1;
        clamp64 = S32Max;
      end else if (v < -66'sh080000000) begin
        sat = 1'b1;
        clamp64 = S32Min;
      end else begin
        clamp64 = v[DataWidth-1:0];
      end
    end
  endfunction

endpackage

// ===== sv/pvp_div_cell.sv =====
// One cell of the restoring divider chain: BITS quotient bits for three lanes.
// Uses pvp_pkg. Instantiated in a row by the top level.
module pvp_div_cell
  import pvp_pkg::*;
#(
  parameter int BITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  pvp_ctrl_t     ctrl_in,
  input  pvp_lane_t     lane_in [3],
  input  logic [DataWidth-1:0] pass_in [3],
  output pvp_ctrl_t     ctrl_out,
  output pvp_lane_t     lane_out [3],
  output logic [DataWidth-1:0] pass_out [3]
);

  localparam int RemW = DataWidth + 48;

  pvp_lane_t lane_next [3];

  always_comb begin
    logic [RemW-1:0] r;
    logic [QuotWidth-1:0] q;
    logic [RemW-1:0] d;
    for (int l = 0; l < 3; l++) begin
      r = lane_in[l].rem;
      q = lane_in[l].quot;
      for (int b = 0; b < BITS; b++) begin
        // remainder holds the high part aligned so the divisor compares at the top
        d = {ctrl_in.w_mag, {(RemW-DataWidth-1){1'b0}}};
        r = {r[RemW-2:0], 1'b0};
        q = {q[QuotWidth-2:0], 1'b0};
        if (r[RemW-1 -: DataWidth+2] >= {1'b0, d[RemW-1 -: DataWidth+1]}) begin
          r[RemW-1 -: DataWidth+2] = r[RemW-1 -: DataWidth+2] -
                                     {1'b0, d[RemW-1 -: DataWidth+1]};
          q[0] = 1'b1;
        end
      end
      lane_next[l].neg  = lane_in[l].neg;
      lane_next[l].ovf  = lane_in[l].ovf;
      lane_next[l].quot = q;
      lane_next[l].rem  = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_out.w_zero <= ctrl_in.w_zero;
      ctrl_out.sat    <= ctrl_in.sat;
      ctrl_out.w_mag  <= ctrl_in.w_mag;
      for (int l = 0; l < 3; l++) begin
        lane_out[l] <= lane_next[l];
        pass_out[l] <= pass_in[l];
      end
    end
  end

endmodule

// ===== sv/perspective_vertex_projection_unit.sv =====
// Perspective vertex projection unit, top level.
// Uses pvp_pkg and a row of pvp_div_cell instances.
//
// Usage: configuration is written over cfg_valid/cfg_ready/cfg_index/cfg_data
// (ready is always high; index beyond six is ignored), only while idle.
// A vertex transfers on in_valid && !in_stall; the projected result transfers
// on out_valid && !out_stall. One vertex per cycle is taken when the output
// is not stalled.
// Pipeline: three register stages for camera subtract, scale and divide set-up,
// one per divider cell (QuotWidth/Bits cells, eleven at the defaults) and the
// output register.
// Throughput: one vertex a cycle unless the output stalls, set by the chain of
// divider cells, each developing three quotient bits.
// A stall on a valid output freezes the whole chain and raises in_stall.
// Reset clears configuration to its defaults and empties the pipeline.
// w == 0 bypasses the divide: the scaled vector comes out with w_zero set.
// saturated reports clamping in the subtract, scale or divide steps.
module perspective_vertex_projection_unit
  import pvp_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [DataWidth-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [DataWidth-1:0] vertex_x,
  input  logic signed [DataWidth-1:0] vertex_y,
  input  logic signed [DataWidth-1:0] vertex_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [DataWidth-1:0] proj_x,
  output logic signed [DataWidth-1:0] proj_y,
  output logic signed [DataWidth-1:0] proj_z,
  output logic w_zero,
  output logic saturated
);

  localparam int Bits = 3;
  localparam int NumCells = QuotWidth / Bits;
  localparam int RemW = DataWidth + 48;

  logic signed [DataWidth-1:0] x_scale, y_scale, depth_scale, depth_offset;
  logic signed [DataWidth-1:0] camera_x, camera_y, camera_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale <= XScaleReset;
      y_scale <= YScaleReset;
      depth_scale <= DepthScaleReset;
      depth_offset <= '0;
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegXScale:      x_scale <= cfg_data;
        RegYScale:      y_scale <= cfg_data;
        RegDepthScale:  depth_scale <= cfg_data;
        RegDepthOffset: depth_offset <= cfg_data;
        RegCameraX:     camera_x <= cfg_data;
        RegCameraY:     camera_y <= cfg_data;
        RegCameraZ:     camera_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the output holds a result that is stalled.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: camera subtract.
  logic s1_valid, s1_sat;
  logic signed [DataWidth-1:0] s1_d [3];
  logic sat_d [3];
  logic signed [DataWidth-1:0] d_next [3];

  always_comb begin
    d_next[0] = clamp64(66'(vertex_x) - 66'(camera_x), sat_d[0]);
    d_next[1] = clamp64(66'(vertex_y) - 66'(camera_y), sat_d[1]);
    d_next[2] = clamp64(66'(vertex_z) - 66'(camera_z), sat_d[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d <= d_next;
      s1_sat <= sat_d[0] | sat_d[1] | sat_d[2];
    end
  end

  // Stage 2: products, registered before the shift and clamp.
  logic s2_valid, s2_sat;
  logic signed [63:0] s2_p [3];
  logic signed [DataWidth-1:0] s2_dz;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p[0] <= s1_d[0] * x_scale;
      s2_p[1] <= s1_d[1] * y_scale;
      s2_p[2] <= s1_d[2] * depth_scale;
      s2_dz <= s1_d[2];
      s2_sat <= s1_sat;
    end
  end

  // Stage 3: arithmetic shift floors; add offset, clamp, set up divide.
  logic signed [DataWidth-1:0] v [3];
  logic sat_v [3];
  logic signed [DataWidth:0] w;
  logic [DataWidth:0] w_mag;

  always_comb begin
    v[0] = clamp64(66'(s2_p[0] >>> FRAC_BITS), sat_v[0]);
    v[1] = clamp64(66'(s2_p[1] >>> FRAC_BITS), sat_v[1]);
    v[2] = clamp64(66'(s2_p[2] >>> FRAC_BITS) + 66'(depth_offset), sat_v[2]);
    w = -(33'(s2_dz));
    w_mag = w[DataWidth] ? 33'(-w) : 33'(w);
  end

  pvp_ctrl_t chain_ctrl [NumCells+1];
  pvp_lane_t chain_lane [NumCells+1][3];
  logic [DataWidth-1:0] chain_pass [NumCells+1][3];

  always_ff @(posedge clk) begin
    if (rst) chain_ctrl[0].valid <= 1'b0;
    else if (en) chain_ctrl[0].valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    logic [DataWidth-1:0] mag;
    if (en) begin
      chain_ctrl[0].w_zero <= (w == '0);
      chain_ctrl[0].sat <= s2_sat | sat_v[0] | sat_v[1] | sat_v[2];
      chain_ctrl[0].w_mag <= w_mag;
      for (int l = 0; l < 3; l++) begin
        mag = v[l][DataWidth-1] ? -v[l] : v[l];
        chain_lane[0][l].neg <= v[l][DataWidth-1] ^ w[DataWidth];
        // quotient of 2^QuotWidth or more: the top of the numerator already holds |w|
        chain_lane[0][l].ovf <= {1'b0, mag >> (QuotWidth - FRAC_BITS)} >= w_mag;
        chain_lane[0][l].quot <= '0;
        // numerator |v| << FRAC_BITS, placed so quotient bits drop in from the top
        chain_lane[0][l].rem <= RemW'({(DataWidth+1)'(0), 1'b0, mag}) <<
                                (FRAC_BITS + RemW - DataWidth - 2 - QuotWidth);
        chain_pass[0][l] <= v[l];
      end
    end
  end

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    pvp_div_cell #(.BITS(Bits)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctrl_in(chain_ctrl[c]), .lane_in(chain_lane[c]), .pass_in(chain_pass[c]),
      .ctrl_out(chain_ctrl[c+1]), .lane_out(chain_lane[c+1]),
      .pass_out(chain_pass[c+1])
    );
  end

  // Output stage: sign, clamp and w == 0 bypass.
  pvp_ctrl_t last;
  logic signed [DataWidth-1:0] res [3];
  logic sat_q [3];

  assign last = chain_ctrl[NumCells];

  always_comb begin
    logic signed [65:0] q;
    for (int l = 0; l < 3; l++) begin
      q = 66'(chain_lane[NumCells][l].quot);
      if (chain_lane[NumCells][l].ovf) q = 66'sh100000000;
      if (chain_lane[NumCells][l].neg) q = -q;
      res[l] = clamp64(q, sat_q[l]);
      if (last.w_zero) begin
        res[l] = chain_pass[NumCells][l];
        sat_q[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= last.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_x <= res[0];
      proj_y <= res[1];
      proj_z <= res[2];
      w_zero <= last.w_zero;
      saturated <= last.sat | sat_q[0] | sat_q[1] | sat_q[2];
    end
  end

  // A stalled result must stay put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(proj_x) && $stable(saturated))
    else $error("stalled result changed");

  // Input is held off exactly while the output is blocked.
  assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  // A freshly loaded w_zero came from the end of the chain.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero && $past(en) |-> $past(last.w_zero))
    else $error("w_zero lost in chain");

endmodule
